@@ rtl/assert_macros.svh @@
// assertion macros used by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: assertion failed");
`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("%m: assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/tdc_pkg.sv @@
// types, constants and helper functions of the tensor descriptor checker
package tdc_pkg;

    localparam int MAX_RANK = 8;
    localparam int DIM_W    = $clog2(MAX_RANK + 2);
    localparam int ESZ_W    = 3;
    localparam int STAT_W   = 3;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_RANK  = 3'd1,
        ST_BAD_DTYPE = 3'd2,
        ST_BAD_DIM   = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    typedef enum logic {
        MODE_CHECK = 1'b0,
        MODE_BUILD = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        DT_F32     = 3'd0,
        DT_F16     = 3'd1,
        DT_BF16    = 3'd2,
        DT_I8      = 3'd3,
        DT_U8      = 3'd4,
        DT_I32     = 3'd5,
        DT_I4      = 3'd6,
        DT_INVALID = 3'd7
    } t_dtype;

    typedef struct packed {
        t_mode              action;
        t_dtype             dtype;
        logic [63:0]        base_offset;
        logic [63:0]        extent;
        logic signed [63:0] stride;
        logic               last;
    } t_in_word;

    typedef struct packed {
        logic [62:0] stride_out;
        logic [63:0] required_bytes;
        t_status     status;
        logic        contiguous;
        logic        last_out;
    } t_out_word;

    typedef struct packed {
        logic        ovf;
        logic [63:0] prod;
    } t_mul;

    function automatic logic [ESZ_W-1:0] size_of_type(input t_dtype t);
        logic [ESZ_W-1:0] s;
        case (t)
            DT_F32:     s = 3'd4;
            DT_F16:     s = 3'd2;
            DT_BF16:    s = 3'd2;
            DT_I8:      s = 3'd1;
            DT_U8:      s = 3'd1;
            DT_I32:     s = 3'd4;
            DT_I4:      s = 3'd1;
            DT_INVALID: s = 3'd0;
            default:    s = 3'd0;
        endcase
        return s;
    endfunction

    // 64x64 product with overflow flag from two 32x32 products:
    // both high halves set always overflows, else one cross term remains
    function automatic t_mul mul_ovf(input logic [63:0] a, input logic [63:0] b);
        logic [31:0] xa;
        logic [31:0] xb;
        logic [63:0] low;
        logic [63:0] mid;
        logic [64:0] sum;
        t_mul        r;
        xa    = (a[63:32] != 32'd0) ? a[63:32] : b[63:32];
        xb    = (a[63:32] != 32'd0) ? b[31:0] : a[31:0];
        low   = 64'(a[31:0]) * 64'(b[31:0]);
        mid   = 64'(xa) * 64'(xb);
        sum   = {1'b0, low} + {1'b0, mid[31:0], 32'd0};
        r.prod = sum[63:0];
        r.ovf  = ((a[63:32] != 32'd0) && (b[63:32] != 32'd0)) ||
                 (mid[63:32] != 32'd0) || sum[64];
        return r;
    endfunction

    // lowest code wins: keep the smallest nonzero code
    function automatic t_status note_error(input t_status cur, input t_status code);
        return ((cur == ST_OK) || (code < cur)) ? code : cur;
    endfunction

endpackage

@@ rtl/tdc_if.sv @@
// valid/ready channels for descriptor words and result words
interface tdc_in_if;
    logic               valid;
    logic               ready;
    tdc_pkg::t_mode     action;
    tdc_pkg::t_dtype    dtype;
    logic [63:0]        base_offset;
    logic [63:0]        extent;
    logic signed [63:0] stride;
    logic               last;

    modport source(output valid, action, dtype, base_offset, extent, stride, last,
                   input ready);
    modport sink(input valid, action, dtype, base_offset, extent, stride, last,
                 output ready);
endinterface

interface tdc_out_if;
    logic             valid;
    logic             ready;
    logic [62:0]      stride_out;
    logic [63:0]      required_bytes;
    tdc_pkg::t_status status;
    logic             contiguous;
    logic             last_out;

    modport source(output valid, stride_out, required_bytes, status, contiguous, last_out,
                   input ready);
    modport sink(input valid, stride_out, required_bytes, status, contiguous, last_out,
                 output ready);
endinterface

@@ rtl/tensor_descriptor_checker.sv @@
// tensor descriptor checker: validates strided descriptors or builds contiguous strides
//
// i_in carries one dimension per word, innermost first; last marks the outermost
// dimension. action, dtype and base_offset are taken from the first word only.
// check mode: no result until the last word, then one word with status,
// required_bytes and contiguous. build mode: one result word per input word,
// holding that dimension's contiguous stride and the status known so far.
// an accepted word is held in an input register; then a single pass through a
// 64-bit multiplier (two 32x32 products) and adder updates the descriptor state
// and, when a result is due, loads the result register that drives o_out.valid.
// one word per cycle is sustained while o_out is not stalled; the multiply-add
// feedback of the running size sets the cycle time.
// when o_out is stalled the result register holds, one more word waits in the
// input register, and i_in.ready drops until the result word is taken.
// synchronous reset clears the valid flags of both registers and starts a fresh descriptor.
`include "assert_macros.svh"

module tensor_descriptor_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tdc_in_if.sink     i_in,
    tdc_out_if.source  o_out
);

    logic                            r_in_valid;
    tdc_pkg::t_in_word               r_in;
    logic                            r_out_valid;
    tdc_pkg::t_out_word              r_out;

    logic                            r_in_desc;
    tdc_pkg::t_mode                  r_mode;
    logic [tdc_pkg::ESZ_W-1:0]       r_esz;
    logic [63:0]                     r_end;
    logic [63:0]                     r_rp;
    tdc_pkg::t_status                r_err;
    logic [tdc_pkg::DIM_W-1:0]       r_dim;
    logic                            r_contig;

    logic                            n_in_desc;
    tdc_pkg::t_mode                  n_mode;
    logic [tdc_pkg::ESZ_W-1:0]       n_esz;
    logic [63:0]                     n_end;
    logic [63:0]                     n_rp;
    tdc_pkg::t_status                n_err;
    logic [tdc_pkg::DIM_W-1:0]       n_dim;
    logic                            n_contig;
    tdc_pkg::t_out_word              n_out;
    logic                            emit;

    logic [tdc_pkg::DIM_W-1:0]       dim_e;
    logic [63:0]                     rp_e;
    logic                            contig_e;
    logic                            process;
    logic                            bad_dim;
    logic [63:0]                     mul_a;
    logic [63:0]                     mul_b;
    tdc_pkg::t_mul                   mul_r;
    logic [64:0]                     off_sum;
    logic [64:0]                     rp_sum;
    logic [64:0]                     req_sum;
    tdc_pkg::t_status                st;
    logic                            advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // first word of a descriptor loads fresh state
    always_comb begin
        if (!r_in_desc) begin
            n_mode   = r_in.action;
            n_esz    = tdc_pkg::size_of_type(r_in.dtype);
            rp_e     = 64'(n_esz);
            n_err    = (n_esz == '0) ? tdc_pkg::ST_BAD_DTYPE : tdc_pkg::ST_OK;
            dim_e    = '0;
            contig_e = 1'b1;
            n_end    = r_in.base_offset;
        end else begin
            n_mode   = r_mode;
            n_esz    = r_esz;
            rp_e     = r_rp;
            n_err    = r_err;
            dim_e    = r_dim;
            contig_e = r_contig;
            n_end    = r_end;
        end

        process = dim_e < tdc_pkg::DIM_W'(tdc_pkg::MAX_RANK);
        n_dim   = process ? dim_e + 1'b1 : tdc_pkg::DIM_W'(tdc_pkg::MAX_RANK + 1);
        bad_dim = (r_in.extent == 64'd0) || (r_in.stride == 64'sd0) || r_in.stride[63];

        mul_a = (n_mode == tdc_pkg::MODE_BUILD) ? rp_e : r_in.extent - 64'd1;
        mul_b = (n_mode == tdc_pkg::MODE_BUILD) ? r_in.extent : r_in.stride;
        mul_r = tdc_pkg::mul_ovf(mul_a, mul_b);

        off_sum = {1'b0, n_end} + {1'b0, mul_r.prod};
        // stride*extent as (extent-1)*stride + stride
        rp_sum  = {1'b0, mul_r.prod} + {1'b0, r_in.stride};

        n_rp     = rp_e;
        n_contig = contig_e;
        n_out    = '0;
        emit     = 1'b0;

        if (n_mode == tdc_pkg::MODE_CHECK) begin
            if (process) begin
                if (bad_dim || mul_r.ovf || off_sum[64]) begin
                    n_err = tdc_pkg::note_error(n_err, tdc_pkg::ST_BAD_DIM);
                end else begin
                    n_end = off_sum[63:0];
                end
                if (contig_e) begin
                    if (r_in.stride != rp_e) begin
                        n_contig = 1'b0;
                    end else if (mul_r.ovf || rp_sum[64]) begin
                        n_contig = 1'b0;
                    end else begin
                        n_rp = rp_sum[63:0];
                    end
                end
            end
        end else begin
            if (process && n_err == tdc_pkg::ST_OK) begin
                n_out.stride_out = rp_e[62:0];
                if (r_in.extent == 64'd0) begin
                    n_err = tdc_pkg::note_error(n_err, tdc_pkg::ST_BAD_DIM);
                end else if (mul_r.ovf || mul_r.prod[63]) begin
                    n_err = tdc_pkg::note_error(n_err, tdc_pkg::ST_OVERFLOW);
                end else begin
                    n_rp = mul_r.prod;
                end
            end else if (process && r_in.extent == 64'd0) begin
                n_err = tdc_pkg::note_error(n_err, tdc_pkg::ST_BAD_DIM);
            end
        end

        st      = (n_dim > tdc_pkg::DIM_W'(tdc_pkg::MAX_RANK)) ? tdc_pkg::ST_BAD_RANK : n_err;
        req_sum = {1'b0, n_end} + 65'(n_esz);

        if (n_mode == tdc_pkg::MODE_CHECK) begin
            if (st == tdc_pkg::ST_OK && req_sum[64]) begin
                st = tdc_pkg::ST_OVERFLOW;
            end
            emit                 = r_in.last;
            n_out.required_bytes = (st == tdc_pkg::ST_OK) ? req_sum[63:0] : 64'd0;
            n_out.contiguous     = (st == tdc_pkg::ST_OK) && n_contig;
        end else begin
            emit             = 1'b1;
            n_out.contiguous = r_in.last && (st == tdc_pkg::ST_OK);
        end
        n_out.status   = st;
        n_out.last_out = r_in.last;
        n_in_desc      = !r_in.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_in_desc   <= 1'b0;
            r_mode      <= tdc_pkg::MODE_CHECK;
            r_esz       <= '0;
            r_end       <= '0;
            r_rp        <= '0;
            r_err       <= tdc_pkg::ST_OK;
            r_dim       <= '0;
            r_contig    <= 1'b1;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (advance) begin
                r_in_desc <= n_in_desc;
                r_mode    <= n_mode;
                r_esz     <= n_esz;
                r_end     <= n_end;
                r_rp      <= n_rp;
                r_err     <= n_err;
                r_dim     <= n_dim;
                r_contig  <= n_contig;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.action      <= i_in.action;
            r_in.dtype       <= i_in.dtype;
            r_in.base_offset <= i_in.base_offset;
            r_in.extent      <= i_in.extent;
            r_in.stride      <= i_in.stride;
            r_in.last        <= i_in.last;
        end
        if (advance && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.stride_out     = r_out.stride_out;
    assign o_out.required_bytes = r_out.required_bytes;
    assign o_out.status         = r_out.status;
    assign o_out.contiguous     = r_out.contiguous;
    assign o_out.last_out       = r_out.last_out;

    // rank count saturates one past the limit
    `ASSERT_CLK(a_dim_sat, r_dim <= tdc_pkg::DIM_W'(tdc_pkg::MAX_RANK + 1))
    // rank errors come only from the count, never from the stored code
    `ASSERT_CLK(a_err_no_rank, r_err != tdc_pkg::ST_BAD_RANK)
    // contiguous only on a clean closing word
    `ASSERT_CLK(a_contig_ok, r_out_valid && r_out.contiguous |->
        (r_out.status == tdc_pkg::ST_OK) && r_out.last_out)
    // byte count only on a clean closing word
    `ASSERT_CLK(a_req_ok, r_out_valid && (r_out.required_bytes != 64'd0) |->
        (r_out.status == tdc_pkg::ST_OK) && r_out.last_out)

endmodule
